[rtl/core/cfdc_pkg.sv]
// shared constants and types for the card frame deframer
package cfdc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam logic [7:0]  HDR_FIRST   = 8'hAA;
    localparam logic [7:0]  HDR_LAST    = 8'hAB;
    localparam int unsigned PAYLOAD_LEN = 5;
    localparam int unsigned KEPT_BYTES  = 4;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned IDX_W       = (KEPT_BYTES > 1) ? $clog2(KEPT_BYTES) : 1;

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_HDR2  = 5'b00010,
        PH_HDR3  = 5'b00100,
        PH_PAY   = 5'b01000,
        PH_CHECK = 5'b10000
    } phase_t;

endpackage

[rtl/core/cfdc_if.sv]
// valid/ready channels for received bytes and card bytes
interface cfdc_rx_if;
    logic                         valid;
    logic                         ready;
    logic [cfdc_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfdc_card_if;
    logic                         valid;
    logic                         ready;
    logic [cfdc_pkg::BYTE_W-1:0]  card_byte;
    logic                         last_byte;

    modport source (output valid, output card_byte, output last_byte, input ready);
    modport sink   (input valid, input card_byte, input last_byte, output ready);
endinterface

[rtl/core/card_frame_deframer_checksum.sv]
// Card frame deframer: hunts for the header AA AA AB, gathers five payload bytes,
// checks their modulo-256 sum against the following byte and, on a match, sends the
// first four payload bytes out as card bytes with last_byte set on the fourth.
// Received bytes are taken one per cycle while the block is not busy. After a checksum
// match the rx channel is held off while the four card bytes are loaded into the
// output register, one per cycle when the register is empty or the card side takes
// its byte. The output register lets the next received byte be taken while the last
// card byte still waits to be taken.
module card_frame_deframer_checksum
(
    input  logic               clk,
    input  logic               rst_n,
    cfdc_rx_if.sink            rx,
    cfdc_card_if.source        card
);

    cfdc_pkg::phase_t                   phase_reg, phase_next;
    logic [cfdc_pkg::CNT_W-1:0]         pay_cnt_reg, pay_cnt_next;
    logic [7:0]                         sum_reg, sum_next;
    logic [7:0]                         payload_reg [cfdc_pkg::KEPT_BYTES];
    logic                               wr_en;
    logic                               match;
    logic                               rx_acc;

    logic                               busy_reg, busy_next;
    logic [cfdc_pkg::CNT_W-1:0]         emit_idx_reg, emit_idx_next;
    logic                               load;
    logic                               last_emit;

    logic                               out_valid_reg, out_valid_next;
    logic [7:0]                         card_byte_reg;
    logic                               last_byte_reg;

    assign rx.ready       = !busy_reg;
    assign rx_acc         = rx.valid && !busy_reg;
    assign card.valid     = out_valid_reg;
    assign card.card_byte = card_byte_reg;
    assign card.last_byte = last_byte_reg;

    // frame tracking
    always_comb
    begin
        phase_next   = phase_reg;
        pay_cnt_next = pay_cnt_reg;
        sum_next     = sum_reg;
        wr_en        = 1'b0;
        match        = 1'b0;
        if (rx_acc)
        begin
            unique case (phase_reg)
                cfdc_pkg::PH_HUNT:
                begin
                    phase_next = (rx.rx_byte == cfdc_pkg::HDR_FIRST) ?
                                 cfdc_pkg::PH_HDR2 : cfdc_pkg::PH_HUNT;
                end
                cfdc_pkg::PH_HDR2:
                begin
                    phase_next = (rx.rx_byte == cfdc_pkg::HDR_FIRST) ?
                                 cfdc_pkg::PH_HDR3 : cfdc_pkg::PH_HUNT;
                end
                cfdc_pkg::PH_HDR3:
                begin
                    if (rx.rx_byte == cfdc_pkg::HDR_LAST)
                    begin
                        phase_next   = cfdc_pkg::PH_PAY;
                        sum_next     = 8'd0;
                        pay_cnt_next = '0;
                    end
                    else
                    begin
                        phase_next = cfdc_pkg::PH_HUNT;
                    end
                end
                cfdc_pkg::PH_PAY:
                begin
                    sum_next = sum_reg + rx.rx_byte;
                    wr_en    = (pay_cnt_reg < cfdc_pkg::CNT_W'(cfdc_pkg::KEPT_BYTES));
                    if (pay_cnt_reg == cfdc_pkg::CNT_W'(cfdc_pkg::PAYLOAD_LEN - 1))
                    begin
                        phase_next = cfdc_pkg::PH_CHECK;
                    end
                    else
                    begin
                        pay_cnt_next = pay_cnt_reg + 1'b1;
                    end
                end
                cfdc_pkg::PH_CHECK:
                begin
                    match      = (rx.rx_byte == sum_reg);
                    phase_next = cfdc_pkg::PH_HUNT;
                end
                default:
                begin
                    phase_next = cfdc_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // card byte emission
    assign load      = busy_reg && (!out_valid_reg || card.ready);
    assign last_emit = (emit_idx_reg == cfdc_pkg::CNT_W'(cfdc_pkg::KEPT_BYTES - 1));

    always_comb
    begin
        busy_next      = busy_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg;
        if (card.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (match)
        begin
            busy_next     = 1'b1;
            emit_idx_next = '0;
        end
        else if (load)
        begin
            out_valid_next = 1'b1;
            emit_idx_next  = emit_idx_reg + 1'b1;
            if (last_emit)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cfdc_pkg::PH_HUNT;
            pay_cnt_reg   <= '0;
            sum_reg       <= 8'd0;
            busy_reg      <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pay_cnt_reg   <= pay_cnt_next;
            sum_reg       <= sum_next;
            busy_reg      <= busy_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            payload_reg[pay_cnt_reg[cfdc_pkg::IDX_W-1:0]] <= rx.rx_byte;
        end
        if (load)
        begin
            card_byte_reg <= payload_reg[emit_idx_reg[cfdc_pkg::IDX_W-1:0]];
            last_byte_reg <= last_emit;
        end
    end

endmodule

[rtl/core/cfdc_checker.sv]
// port-level assertions for the card frame deframer, with bind
module cfdc_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    input  logic       rx_ready,
    input  logic       card_valid,
    input  logic       card_ready,
    input  logic [7:0] card_byte,
    input  logic       last_byte
);

    // stalled card beat holds
    a_card_hold: assert property (@(posedge clk) disable iff (!rst_n)
        card_valid && !card_ready |=>
        card_valid && $stable(card_byte) && $stable(last_byte))
        else $error("card beat changed while stalled");

    // card bytes of a frame follow each other without gaps
    a_card_burst: assert property (@(posedge clk) disable iff (!rst_n)
        card_valid && card_ready && !last_byte |=> card_valid)
        else $error("gap inside card byte burst");

    // rx held off whenever a frame is only partly sent
    a_rx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        card_valid && !last_byte |-> !rx_ready)
        else $error("rx taken during card burst");

    // hold-off only starts after an rx beat
    a_hold_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rx_ready) |-> $past(rx_valid))
        else $error("rx hold-off without an rx beat");

endmodule

bind card_frame_deframer_checksum cfdc_checker u_cfdc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_valid   (rx.valid),
    .rx_ready   (rx.ready),
    .card_valid (card.valid),
    .card_ready (card.ready),
    .card_byte  (card.card_byte),
    .last_byte  (card.last_byte)
);
